### sv/mdq_pkg.sv
// ----------------------------------------------------------------------------
// mdq_pkg
// Shared codes, defaults and controller/datapath interface types for the
// multi-deque manager.
// ----------------------------------------------------------------------------
package mdq_pkg;

    localparam int DEF_NUM_QUEUES  = 16;
    localparam int DEF_POOL_DEPTH  = 1024;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_MERGE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_SELF  = 2'd3;

    localparam logic [1:0] RES_ZERO = 2'd0;
    localparam logic [1:0] RES_NEG  = 2'd1;
    localparam logic [1:0] RES_DATA = 2'd2;

    typedef struct packed {
        logic       load;
        logic       qsel_src;
        logic       push_rd;
        logic       push_wr;
        logic       pop_wr;
        logic       mrg_latch;
        logic       mrg_fwd;
        logic       rev_rd;
        logic       rev_wr;
        logic       finish;
        logic [1:0] fin_code;
        logic [1:0] fin_res;
    } ctl_t;

    typedef struct packed {
        logic [1:0] op;
        logic       back;
        logic       t_ok;
        logic       s_ok;
        logic       self_merge;
        logic       q_empty;
        logic       pool_full;
        logic       last_step;
    } stat_t;

endpackage

### sv/mdq_ctrl.sv
// ----------------------------------------------------------------------------
// mdq_ctrl
// Sequencer for one item at a time: decode, node memory read, update, and the
// node-by-node walk of a reversed merge.
// ----------------------------------------------------------------------------
module mdq_ctrl
    import mdq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  stat_t stat,
    output ctl_t  ctl
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_PUSH = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_MTGT = 3'd4;
    localparam logic [2:0] S_RVRD = 3'd5;
    localparam logic [2:0] S_RVWR = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                ctl.qsel_src = (stat.op == OP_MERGE);
                case (stat.op)
                    OP_PUSH:
                    begin
                        if (!stat.t_ok || stat.pool_full)
                        begin
                            ctl.finish   = 1'b1;
                            ctl.fin_code = ST_FULL;
                            state_next   = S_IDLE;
                        end
                        else
                        begin
                            ctl.push_rd = 1'b1;
                            state_next  = S_PUSH;
                        end
                    end
                    OP_POP:
                    begin
                        if (!stat.t_ok || stat.q_empty)
                        begin
                            ctl.finish   = 1'b1;
                            ctl.fin_code = ST_EMPTY;
                            ctl.fin_res  = RES_NEG;
                            state_next   = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_POP;
                        end
                    end
                    OP_MERGE:
                    begin
                        if (!stat.t_ok || !stat.s_ok)
                        begin
                            ctl.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                        else if (stat.self_merge)
                        begin
                            ctl.finish   = 1'b1;
                            ctl.fin_code = ST_SELF;
                            state_next   = S_IDLE;
                        end
                        else if (stat.q_empty)
                        begin
                            ctl.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            ctl.mrg_latch = 1'b1;
                            state_next    = S_MTGT;
                        end
                    end
                    default:
                    begin
                        ctl.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_PUSH:
            begin
                ctl.push_wr = 1'b1;
                ctl.finish  = 1'b1;
                state_next  = S_IDLE;
            end
            S_POP:
            begin
                ctl.pop_wr  = 1'b1;
                ctl.finish  = 1'b1;
                ctl.fin_res = RES_DATA;
                state_next  = S_IDLE;
            end
            S_MTGT:
            begin
                if (!stat.back)
                begin
                    ctl.mrg_fwd = 1'b1;
                    ctl.finish  = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ctl.rev_rd = 1'b1;
                    state_next = S_RVWR;
                end
            end
            S_RVRD:
            begin
                ctl.rev_rd = 1'b1;
                state_next = S_RVWR;
            end
            S_RVWR:
            begin
                ctl.rev_wr = 1'b1;
                if (stat.last_step)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RVRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_DEC))
        else $error("accepted item did not enter decode");
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> (state_reg == S_IDLE))
        else $error("finish did not return to idle");
`endif

endmodule

### sv/mdq_dpath.sv
// ----------------------------------------------------------------------------
// mdq_dpath
// Node memories, queue descriptor table, free list and result registers.
// ----------------------------------------------------------------------------
module mdq_dpath
    import mdq_pkg::*;
#(
    parameter int NUM_QUEUES  = DEF_NUM_QUEUES,
    parameter int POOL_DEPTH  = DEF_POOL_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctl_t               ctl,
    output stat_t              stat,
    input  logic [1:0]         opcode,
    input  logic [3:0]         target_queue,
    input  logic [3:0]         source_queue,
    input  logic               at_back,
    input  logic signed [31:0] push_value,
    output logic               done,
    output logic signed [31:0] pop_value,
    output logic [1:0]         status
);

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int NW = $clog2(POOL_DEPTH);
    localparam int LW = $clog2(POOL_DEPTH + 1);

    logic [1:0]             op_reg;
    logic [3:0]             tq_reg;
    logic [3:0]             sq_reg;
    logic                   back_reg;
    logic [VALUE_WIDTH-1:0] pv_reg;

    logic [NW-1:0] qfirst_reg [NUM_QUEUES];
    logic [NW-1:0] qlast_reg  [NUM_QUEUES];
    logic [LW-1:0] qlen_reg   [NUM_QUEUES];

    logic [NW-1:0] free_head_reg;
    logic [LW-1:0] free_len_reg;
    logic [LW-1:0] fresh_reg;

    logic [NW-1:0] sfirst_reg;
    logic [NW-1:0] slast_reg;
    logic [LW-1:0] slen_reg;
    logic [NW-1:0] cur_reg;
    logic [LW-1:0] cnt_reg;

    logic [VALUE_WIDTH-1:0] data_mem [POOL_DEPTH];
    logic [NW-1:0]          fwd_mem  [POOL_DEPTH];
    logic [NW-1:0]          bwd_mem  [POOL_DEPTH];
    logic [VALUE_WIDTH-1:0] data_rd_reg;
    logic [NW-1:0]          fwd_rd_reg;
    logic [NW-1:0]          bwd_rd_reg;

    logic               done_reg;
    logic signed [31:0] val_reg;
    logic [1:0]         status_reg;

    logic [QW-1:0] qi;
    logic [QW-1:0] si;
    logic [NW-1:0] cur_first;
    logic [NW-1:0] cur_last;
    logic [LW-1:0] cur_len;
    logic          qe;
    logic          use_free;
    logic [NW-1:0] push_nd;
    logic [NW-1:0] pop_nd;
    logic [NW-1:0] fwd_raddr;
    logic [NW-1:0] bwd_raddr;
    logic          fwd_we;
    logic [NW-1:0] fwd_waddr;
    logic [NW-1:0] fwd_wdata;
    logic          bwd_we;
    logic [NW-1:0] bwd_waddr;
    logic [NW-1:0] bwd_wdata;

    assign qi        = ctl.qsel_src ? QW'(sq_reg) : QW'(tq_reg);
    assign si        = QW'(sq_reg);
    assign cur_first = qfirst_reg[qi];
    assign cur_last  = qlast_reg[qi];
    assign cur_len   = qlen_reg[qi];
    assign qe        = (cur_len == '0);
    assign use_free  = (free_len_reg != '0);
    assign push_nd   = use_free ? free_head_reg : fresh_reg[NW-1:0];
    assign pop_nd    = back_reg ? cur_last : cur_first;
    assign fwd_raddr = ctl.push_rd ? free_head_reg : pop_nd;
    assign bwd_raddr = ctl.rev_rd ? cur_reg : pop_nd;

    assign stat.op         = op_reg;
    assign stat.back       = back_reg;
    assign stat.t_ok       = (32'(tq_reg) < NUM_QUEUES);
    assign stat.s_ok       = (32'(sq_reg) < NUM_QUEUES);
    assign stat.self_merge = (tq_reg == sq_reg);
    assign stat.q_empty    = qe;
    assign stat.pool_full  = !use_free && (32'(fresh_reg) == POOL_DEPTH);
    assign stat.last_step  = (cnt_reg == LW'(1));

    always_comb
    begin
        fwd_we    = 1'b0;
        fwd_waddr = cur_last;
        fwd_wdata = push_nd;
        bwd_we    = 1'b0;
        bwd_waddr = push_nd;
        bwd_wdata = cur_last;
        if (ctl.push_wr && !qe)
        begin
            fwd_we = 1'b1;
            bwd_we = 1'b1;
            if (!back_reg)
            begin
                fwd_waddr = push_nd;
                fwd_wdata = cur_first;
                bwd_waddr = cur_first;
                bwd_wdata = push_nd;
            end
        end
        if (ctl.pop_wr)
        begin
            fwd_we    = 1'b1;
            fwd_waddr = pop_nd;
            fwd_wdata = free_head_reg;
        end
        if (ctl.mrg_fwd && !qe)
        begin
            fwd_we    = 1'b1;
            fwd_wdata = sfirst_reg;
            bwd_we    = 1'b1;
            bwd_waddr = sfirst_reg;
        end
        if (ctl.rev_wr && !qe)
        begin
            fwd_we    = 1'b1;
            fwd_wdata = cur_reg;
            bwd_we    = 1'b1;
            bwd_waddr = cur_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push_wr)
        begin
            data_mem[push_nd] <= pv_reg;
        end
        if (fwd_we)
        begin
            fwd_mem[fwd_waddr] <= fwd_wdata;
        end
        if (bwd_we)
        begin
            bwd_mem[bwd_waddr] <= bwd_wdata;
        end
        data_rd_reg <= data_mem[pop_nd];
        fwd_rd_reg  <= fwd_mem[fwd_raddr];
        bwd_rd_reg  <= bwd_mem[bwd_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg   <= opcode;
            tq_reg   <= target_queue;
            sq_reg   <= source_queue;
            back_reg <= at_back;
            pv_reg   <= VALUE_WIDTH'($unsigned(push_value));
        end
        if (ctl.mrg_latch)
        begin
            sfirst_reg <= cur_first;
            slast_reg  <= cur_last;
            slen_reg   <= cur_len;
        end
        if (ctl.finish)
        begin
            status_reg <= ctl.fin_code;
            case (ctl.fin_res)
                RES_NEG:  val_reg <= -32'sd1;
                RES_DATA: val_reg <= 32'($unsigned(data_rd_reg));
                default:  val_reg <= '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                qfirst_reg[i] <= '0;
                qlast_reg[i]  <= '0;
                qlen_reg[i]   <= '0;
            end
            free_head_reg <= '0;
            free_len_reg  <= '0;
            fresh_reg     <= '0;
            cur_reg       <= '0;
            cnt_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.finish;
            if (ctl.push_wr)
            begin
                if (qe)
                begin
                    qfirst_reg[qi] <= push_nd;
                    qlast_reg[qi]  <= push_nd;
                end
                else if (back_reg)
                begin
                    qlast_reg[qi] <= push_nd;
                end
                else
                begin
                    qfirst_reg[qi] <= push_nd;
                end
                qlen_reg[qi] <= cur_len + LW'(1);
                if (use_free)
                begin
                    free_head_reg <= fwd_rd_reg;
                    free_len_reg  <= free_len_reg - LW'(1);
                end
                else
                begin
                    fresh_reg <= fresh_reg + LW'(1);
                end
            end
            if (ctl.pop_wr)
            begin
                if (back_reg)
                begin
                    qlast_reg[qi] <= bwd_rd_reg;
                end
                else
                begin
                    qfirst_reg[qi] <= fwd_rd_reg;
                end
                qlen_reg[qi]  <= cur_len - LW'(1);
                free_head_reg <= pop_nd;
                free_len_reg  <= free_len_reg + LW'(1);
            end
            if (ctl.mrg_latch)
            begin
                cur_reg <= cur_last;
                cnt_reg <= cur_len;
            end
            if (ctl.mrg_fwd)
            begin
                if (qe)
                begin
                    qfirst_reg[qi] <= sfirst_reg;
                end
                qlast_reg[qi] <= slast_reg;
                qlen_reg[qi]  <= cur_len + slen_reg;
                qlen_reg[si]  <= '0;
            end
            if (ctl.rev_wr)
            begin
                if (qe)
                begin
                    qfirst_reg[qi] <= cur_reg;
                end
                qlast_reg[qi] <= cur_reg;
                qlen_reg[qi]  <= cur_len + LW'(1);
                cur_reg       <= bwd_rd_reg;
                cnt_reg       <= cnt_reg - LW'(1);
                if (stat.last_step)
                begin
                    qlen_reg[si] <= '0;
                end
            end
        end
    end

    assign done      = done_reg;
    assign pop_value = val_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (free_len_reg <= fresh_reg))
        else $error("free list longer than nodes handed out");
    a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop_wr |-> !qe)
        else $error("pop update on an empty queue");
`endif

endmodule

### sv/multi_deque_manager.sv
// ----------------------------------------------------------------------------
// multi_deque_manager
// Double-ended queues sharing one pool of doubly linked nodes.
//
// Usage: drive opcode, target_queue, source_queue, at_back and push_value and
// raise start; the item is taken on a clock edge with start high and busy low.
// busy stays high until the item is done. Exactly one result follows each
// item: done is high for one cycle with pop_value and status valid, and the
// receiver cannot stall it.
// Rejected items, including a pop of an empty queue, finish from decode; a
// reversed merge walks every source node. A new item may start in the cycle
// done is high.
// Each push or pop takes one node memory read and one write; a reversed merge
// steps through the source list one node per read/write pair.
// Reset clears all queues, the free list and the fresh-node counter at once;
// node memory content needs no clearing.
// ----------------------------------------------------------------------------
module multi_deque_manager
    import mdq_pkg::*;
#(
    parameter int NUM_QUEUES  = DEF_NUM_QUEUES,
    parameter int POOL_DEPTH  = DEF_POOL_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic [3:0]         target_queue,
    input  logic [3:0]         source_queue,
    input  logic               at_back,
    input  logic signed [31:0] push_value,
    output logic               done,
    output logic signed [31:0] pop_value,
    output logic [1:0]         status
);

    ctl_t  ctl;
    stat_t stat;

    mdq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctl   (ctl)
    );

    mdq_dpath #(
        .NUM_QUEUES  (NUM_QUEUES),
        .POOL_DEPTH  (POOL_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .opcode       (opcode),
        .target_queue (target_queue),
        .source_queue (source_queue),
        .at_back      (at_back),
        .push_value   (push_value),
        .done         (done),
        .pop_value    (pop_value),
        .status       (status)
    );

endmodule
